// ----- sv/ebfa_pkg.sv -----
// Shared types, codes and helpers for the best-fit extent allocator.
// No dependencies; used by the top level, extent_best_fit_allocator.
package ebfa_pkg;

   localparam int POS_BITS     = 30;
   localparam int GROW_BITS    = 31;
   localparam int SHIFT_BITS   = 5;
   localparam int SIZE_BITS    = 34;
   localparam int FREE_SLOTS_C = 64;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [SIZE_BITS-1:0] POS_LIM =
      {{(SIZE_BITS-POS_BITS){1'b0}}, {POS_BITS{1'b1}}};
   localparam logic [GROW_BITS-1:0] SPACE_LIMIT_RST = GROW_BITS'(1) << POS_BITS;

   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_EXTEND = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;
   // reserved code, handled as a free
   localparam logic [1:0] CMD_RSVD   = 2'd3;

   localparam logic [2:0] ST_OK_TABLE  = 3'd0;
   localparam logic [2:0] ST_OK_GROW   = 3'd1;
   localparam logic [2:0] ST_NO_SPACE  = 3'd2;
   localparam logic [2:0] ST_DBL_FREE  = 3'd3;
   localparam logic [2:0] ST_OVERLAP   = 3'd4;
   localparam logic [2:0] ST_TBL_FULL  = 3'd5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPACE_BASE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPACE_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [POS_BITS-1:0] position;
      logic [POS_BITS-1:0] current_size;
      logic [POS_BITS-1:0] least_size;
      logic [POS_BITS-1:0] most_size;
   } req_type;

   typedef struct packed {
      logic [POS_BITS-1:0] granted_pos;
      logic [POS_BITS-1:0] granted_size;
      logic                in_place;
      logic [2:0]          status;
   } rsp_type;

   function automatic logic [SIZE_BITS-1:0] cell_of(input logic [SHIFT_BITS-1:0] shift);
      cell_of = SIZE_BITS'(1) << shift;
   endfunction

   function automatic logic [SIZE_BITS-1:0] round_up(input logic [POS_BITS-1:0] x,
                                                     input logic [SHIFT_BITS-1:0] shift);
      logic [SIZE_BITS-1:0] c;
      c = cell_of(shift);
      round_up = (SIZE_BITS'(x) + c - SIZE_BITS'(1)) & ~(c - SIZE_BITS'(1));
   endfunction

endpackage

// ----- sv/extent_best_fit_allocator.sv -----
// Best-fit extent allocator with coalescing: top level.
// Depends on ebfa_pkg and ebfa_ram (free-extent table storage).
//
// Usage:
//   req channel carries one command (allocate, extend in place, free) per
//   transaction; rsp channel returns exactly one result per command.
//   csr channel writes cell_shift, space_base and space_limit; write only
//   while no command is in flight. csr_ready is always high.
// Command flow:
//   One command at a time. Each command sweeps the free-extent RAM once,
//   one slot per cycle through its single read port; the result is then
//   decided and registered, and rsp_valid rises.
//   The next request is accepted the cycle after the result is taken.
// Reset:
//   Synchronous, active high. Clears all slot valid bits, the growth
//   pointer and the CSR registers to their defaults; the RAM contents are
//   not cleared, slots are only read through their valid bits.
// Stall:
//   The result is held in the output register until rsp_ready; req_ready
//   stays low meanwhile.
module extent_best_fit_allocator #(
   parameter int FREE_SLOTS = ebfa_pkg::FREE_SLOTS_C
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ebfa_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ebfa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ebfa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [31:0]                          csr_wdata
);
   import ebfa_pkg::*;

   localparam int IW = $clog2(FREE_SLOTS);
   localparam int SW = SIZE_BITS;
   localparam int PB = POS_BITS;
   localparam logic [IW-1:0] LAST = IW'(FREE_SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DEC  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [SHIFT_BITS-1:0] shift_ff;
   logic [PB-1:0]         base_ff;
   logic [GROW_BITS-1:0]  limit_ff, off_ff, off_in;
   logic [FREE_SLOTS-1:0] valid_ff, valid_in;

   // command context
   logic [1:0]    cmd_ff;
   logic [PB-1:0] pos_ff;
   logic [SW-1:0] cur_ff, amin_ff, amax_ff, em_ff;
   logic          nospace_ff;

   // scan bookkeeping
   logic [IW-1:0] rd_addr_ff;
   logic          rd_vld_ff, issue_ff;
   logic [IW-1:0] rd_idx_ff;

   logic          bf_ff, mf_ff, pf_ff, nf_ff, ef_ff;
   logic [IW-1:0] bi_ff, mi_ff, pi_ff, ni_ff, ei_ff;
   logic [PB-1:0] bs_ff, bl_ff, ml_ff, ps_ff, pl_ff, ns_ff, nl_ff;

   rsp_type rsp_ff, res;
   logic    rsp_valid_ff;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [2*PB-1:0] wr_data, rd_data;
   logic [PB-1:0] es, el;

   ebfa_ram #(.WIDTH(2*PB), .DEPTH(FREE_SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign es = rd_data[2*PB-1:PB];
   assign el = rd_data[PB-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // request normalization
   logic [SW-1:0] cs, cap, minr, maxr, curr, amin, mx, amax;
   always_comb begin
      cs   = cell_of(shift_ff);
      cap  = POS_LIM & ~(cs - SW'(1));
      curr = round_up(req_data.current_size, shift_ff);
      minr = round_up(req_data.least_size, shift_ff);
      maxr = round_up(req_data.most_size, shift_ff);
      amin = (minr == '0) ? cs : minr;
      mx   = (maxr < amin) ? amin : maxr;
      amax = (mx > cap) ? cap : mx;
   end

   // decision
   logic [SW-1:0] fend, gsum, ext_end;
   logic          v;
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      valid_in = valid_ff;
      off_in   = off_ff;
      res      = '0;
      fend     = SW'(pos_ff) + cur_ff;
      gsum     = SW'(off_ff) + amin_ff;
      if (state_ff == S_DEC) begin
         if (cmd_ff[1]) begin
            res.status = ST_OK_TABLE;
            if (cur_ff == '0) begin
               res.status = ST_OK_TABLE;
            end else if (fend > POS_LIM) begin
               res.status = ST_OVERLAP;
            end else if (pf_ff && (SW'(ps_ff) + SW'(pl_ff) > SW'(pos_ff))) begin
               res.status = ST_OVERLAP;
            end else if (nf_ff && ns_ff == pos_ff) begin
               res.status = ST_DBL_FREE;
            end else if (nf_ff && SW'(ns_ff) < fend) begin
               res.status = ST_OVERLAP;
            end else if (pf_ff && (SW'(ps_ff) + SW'(pl_ff) == SW'(pos_ff))) begin
               wr_en   = 1'b1;
               wr_addr = pi_ff;
               if (nf_ff && SW'(ns_ff) == fend) begin
                  wr_data = {ps_ff, PB'(SW'(pl_ff) + cur_ff + SW'(nl_ff))};
                  valid_in[ni_ff] = 1'b0;
               end else begin
                  wr_data = {ps_ff, PB'(SW'(pl_ff) + cur_ff)};
               end
            end else if (nf_ff && SW'(ns_ff) == fend) begin
               wr_en   = 1'b1;
               wr_addr = ni_ff;
               wr_data = {pos_ff, PB'(SW'(nl_ff) + cur_ff)};
            end else if (ef_ff) begin
               wr_en   = 1'b1;
               wr_addr = ei_ff;
               wr_data = {pos_ff, PB'(cur_ff)};
               valid_in[ei_ff] = 1'b1;
            end else begin
               res.status = ST_TBL_FULL;
            end
         end else if (cmd_ff == CMD_EXTEND && mf_ff) begin
            res.granted_pos = pos_ff;
            res.in_place    = 1'b1;
            res.status      = ST_OK_TABLE;
            if (cur_ff + SW'(ml_ff) > em_ff) begin
               wr_en   = 1'b1;
               wr_addr = mi_ff;
               wr_data = {PB'(SW'(pos_ff) + em_ff), PB'(SW'(ml_ff) - (em_ff - cur_ff))};
               res.granted_size = PB'(em_ff);
            end else begin
               valid_in[mi_ff] = 1'b0;
               res.granted_size = PB'(cur_ff + SW'(ml_ff));
            end
         end else if (nospace_ff) begin
            res.status = ST_NO_SPACE;
         end else if (bf_ff) begin
            res.granted_pos = bs_ff;
            res.status      = ST_OK_TABLE;
            if (SW'(bl_ff) > amax_ff) begin
               wr_en   = 1'b1;
               wr_addr = bi_ff;
               wr_data = {PB'(SW'(bs_ff) + amax_ff), PB'(SW'(bl_ff) - amax_ff)};
               res.granted_size = PB'(amax_ff);
            end else begin
               valid_in[bi_ff] = 1'b0;
               res.granted_size = bl_ff;
            end
         end else if (gsum > SW'(limit_ff) || SW'(base_ff) + gsum > POS_LIM) begin
            res.status = ST_NO_SPACE;
         end else begin
            res.granted_pos  = PB'(SW'(base_ff) + SW'(off_ff));
            res.granted_size = PB'(amin_ff);
            res.status       = ST_OK_GROW;
            off_in           = GROW_BITS'(gsum);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SCAN;
         S_SCAN: if (rd_vld_ff && rd_idx_ff == LAST) state_in = S_DEC;
         S_DEC:  state_in = S_OUT;
         S_OUT:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign v       = valid_ff[rd_idx_ff];
   assign ext_end = SW'(pos_ff) + cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= '0;
         base_ff      <= '0;
         limit_ff     <= SPACE_LIMIT_RST;
         off_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         issue_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         off_ff   <= off_in;
         valid_ff <= valid_in;
         if (csr_valid) begin
            if (csr_index == CSR_CELL_SHIFT)  shift_ff <= csr_wdata[SHIFT_BITS-1:0];
            if (csr_index == CSR_SPACE_BASE)  base_ff  <= csr_wdata[PB-1:0];
            if (csr_index == CSR_SPACE_LIMIT) limit_ff <= csr_wdata[GROW_BITS-1:0];
         end
         // read pipeline: issue one slot per cycle, data in the cycle after
         rd_vld_ff <= issue_ff;
         if (state_ff == S_IDLE && req_valid) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && rd_addr_ff == LAST) begin
            issue_ff <= 1'b0;
         end
         if (state_ff == S_DEC) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr_ff;
      if (state_ff == S_IDLE) begin
         rd_addr_ff <= '0;
      end else if (issue_ff && rd_addr_ff != LAST) begin
         rd_addr_ff <= rd_addr_ff + IW'(1);
      end
      if (state_ff == S_DEC) begin
         rsp_ff <= res;
      end
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff     <= req_data.cmd;
         pos_ff     <= req_data.position;
         cur_ff     <= curr;
         amin_ff    <= amin;
         amax_ff    <= amax;
         em_ff      <= (amax < curr) ? curr : amax;
         nospace_ff <= amin > amax;
         bf_ff <= 1'b0;
         mf_ff <= 1'b0;
         pf_ff <= 1'b0;
         nf_ff <= 1'b0;
         ef_ff <= 1'b0;
      end else if (state_ff == S_SCAN && rd_vld_ff) begin
         if (v && SW'(el) >= amin_ff &&
             (!bf_ff || el < bl_ff || (el == bl_ff && es < bs_ff))) begin
            bf_ff <= 1'b1;
            bi_ff <= rd_idx_ff;
            bs_ff <= es;
            bl_ff <= el;
         end
         if (v && !mf_ff && SW'(es) == ext_end) begin
            mf_ff <= 1'b1;
            mi_ff <= rd_idx_ff;
            ml_ff <= el;
         end
         if (v && es < pos_ff) begin
            if (!pf_ff || es > ps_ff) begin
               pf_ff <= 1'b1;
               pi_ff <= rd_idx_ff;
               ps_ff <= es;
               pl_ff <= el;
            end
         end else if (v) begin
            if (!nf_ff || es < ns_ff) begin
               nf_ff <= 1'b1;
               ni_ff <= rd_idx_ff;
               ns_ff <= es;
               nl_ff <= el;
            end
         end
         if (!v && !ef_ff) begin
            ef_ff <= 1'b1;
            ei_ff <= rd_idx_ff;
         end
      end
   end

   a_rsp_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT)
      else $error("result valid outside output state");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("request taken while result pending");

   a_write_in_dec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_DEC)
      else $error("table write outside decision cycle");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_NO_SPACE || rsp_ff.status == ST_DBL_FREE ||
       rsp_ff.status == ST_OVERLAP || rsp_ff.status == ST_TBL_FULL))
      |-> (rsp_ff.granted_pos == '0 && rsp_ff.granted_size == '0 && !rsp_ff.in_place))
      else $error("error result carries a grant");
endmodule

// ----- sv/ebfa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ebfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
